FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the point stack.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Implication property checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: lbl");
// Next-cycle implication property checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: lbl");
// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed: lbl");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post)
`define ASSERT_NEXT(lbl, clk, rst, pre, post)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

FILE: rtl/pss_pkg.sv
// Package of types and constants for the searchable point stack.
package pss_pkg;

   localparam int STACK_DEPTH_DEFAULT = 128;
   localparam int SCAN_GROUP = 32;
   localparam int POINT_W = 8;
   localparam int ENTRY_W = 2 * POINT_W;
   localparam int COUNT_OUT_W = 8;

   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // Commands broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic push;
      logic pop;
      logic search;
   } cell_ctl_type;

endpackage

FILE: rtl/pss_cell.sv
// One stack cell: holds an entry, shifts with its neighbours and compares.
module pss_cell (
   input  logic                        clock,
   input  pss_pkg::cell_ctl_type       ctl,
   input  logic [pss_pkg::ENTRY_W-1:0] key,
   input  logic [pss_pkg::ENTRY_W-1:0] upper_entry,
   input  logic [pss_pkg::ENTRY_W-1:0] lower_entry,
   input  logic                        held,
   output logic [pss_pkg::ENTRY_W-1:0] entry,
   output logic                        hit
);

   logic [pss_pkg::ENTRY_W-1:0] entry_ff;
   logic                        hit_ff;

   // On a push the entry moves one place deeper, on a pop one place up.
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         entry_ff <= upper_entry;
      end else if (ctl.pop) begin
         entry_ff <= lower_entry;
      end
      if (ctl.search) begin
         hit_ff <= held && (entry_ff == key);
      end
   end

   assign entry = entry_ff;
   assign hit = hit_ff;

endmodule

FILE: rtl/pss_ctrl.sv
// Controller of the point stack: fill count, hit scan and result registers.
module pss_ctrl #(
   parameter int STACK_DEPTH = pss_pkg::STACK_DEPTH_DEFAULT,
   localparam int CountW = $clog2(STACK_DEPTH + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [1:0]                      opcode,
   input  logic [pss_pkg::ENTRY_W-1:0]     top_entry,
   input  logic [STACK_DEPTH-1:0]          hit_vec,
   output pss_pkg::cell_ctl_type           cell_ctl,
   output logic [CountW-1:0]               count,
   output logic                            busy,
   output logic                            rsp_valid,
   output logic [pss_pkg::POINT_W-1:0]     rsp_top_x,
   output logic [pss_pkg::POINT_W-1:0]     rsp_top_y,
   output logic                            rsp_found,
   output logic                            rsp_is_empty_now,
   output logic [pss_pkg::COUNT_OUT_W-1:0] rsp_entry_count,
   output logic [1:0]                      rsp_status
);

   localparam int NumGroups = (STACK_DEPTH + pss_pkg::SCAN_GROUP - 1) / pss_pkg::SCAN_GROUP;
   localparam int GroupW = (NumGroups > 1) ? $clog2(NumGroups) : 1;
   localparam int PadW = NumGroups * pss_pkg::SCAN_GROUP;

   pss_pkg::state_type state_ff, state_in;
   logic [CountW-1:0]  count_ff, count_in;
   logic [GroupW-1:0]  grp_ff, grp_in;
   logic               found_ff, found_in;
   logic [PadW-1:0]    hit_pad;
   logic               accept;
   logic               grp_last;
   logic               grp_hit;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [pss_pkg::POINT_W-1:0]     rsp_top_x_ff, rsp_top_x_in;
   logic [pss_pkg::POINT_W-1:0]     rsp_top_y_ff, rsp_top_y_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic                            rsp_empty_ff, rsp_empty_in;
   logic [pss_pkg::COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [1:0]                      rsp_status_ff, rsp_status_in;

   assign accept = start && (state_ff == pss_pkg::ST_IDLE);
   assign hit_pad = PadW'(hit_vec);
   assign grp_hit = |hit_pad[grp_ff * pss_pkg::SCAN_GROUP +: pss_pkg::SCAN_GROUP];
   assign grp_last = (grp_ff == GroupW'(NumGroups - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pss_pkg::ST_IDLE: begin
            if (accept && (opcode == pss_pkg::OP_SEARCH)) begin
               state_in = pss_pkg::ST_SCAN;
            end
         end
         pss_pkg::ST_SCAN: begin
            if (grp_last) begin
               state_in = pss_pkg::ST_IDLE;
            end
         end
         default: state_in = pss_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cell_ctl      = '0;
      count_in      = count_ff;
      grp_in        = grp_ff;
      found_in      = found_ff;
      rsp_valid_in  = 1'b0;
      rsp_top_x_in  = '0;
      rsp_top_y_in  = '0;
      rsp_found_in  = 1'b0;
      rsp_status_in = pss_pkg::STATUS_OK;
      unique case (state_ff)
         pss_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (opcode)
                  pss_pkg::OP_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CountW'(STACK_DEPTH)) begin
                        rsp_status_in = pss_pkg::STATUS_OVERFLOW;
                     end else begin
                        cell_ctl.push = 1'b1;
                        count_in = count_ff + CountW'(1);
                     end
                  end
                  pss_pkg::OP_POP: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status_in = pss_pkg::STATUS_UNDERFLOW;
                     end else begin
                        cell_ctl.pop = 1'b1;
                        count_in = count_ff - CountW'(1);
                        rsp_top_x_in = top_entry[pss_pkg::ENTRY_W-1:pss_pkg::POINT_W];
                        rsp_top_y_in = top_entry[pss_pkg::POINT_W-1:0];
                     end
                  end
                  pss_pkg::OP_SEARCH: begin
                     cell_ctl.search = 1'b1;
                     grp_in = '0;
                     found_in = 1'b0;
                  end
                  pss_pkg::OP_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     count_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         pss_pkg::ST_SCAN: begin
            found_in = found_ff || grp_hit;
            grp_in = grp_ff + GroupW'(1);
            if (grp_last) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff || grp_hit;
            end
         end
         default: ;
      endcase
      rsp_empty_in = (count_in == '0);
      rsp_count_in = pss_pkg::COUNT_OUT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pss_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff   <= grp_in;
      found_ff <= found_in;
      if (rsp_valid_in) begin
         rsp_top_x_ff  <= rsp_top_x_in;
         rsp_top_y_ff  <= rsp_top_y_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign count            = count_ff;
   assign busy             = (state_ff != pss_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_top_x        = rsp_top_x_ff;
   assign rsp_top_y        = rsp_top_y_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_is_empty_now = rsp_empty_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

FILE: rtl/point_stack_with_search.sv
// Top level of the searchable point stack: a chain of cells and its controller.
//
//   Channel   Ports                         Handshake
//   request   start, busy, req_*            taken when start is high and busy is low
//   response  rsp_valid, rsp_*              shown for one cycle, taken at its end
//
// Push, pop and clear take one cycle each: the result appears in the cycle after the
// request is taken, and the next request may be taken in that same cycle.
// A search gathers the hit flags of all cells by a scan that covers 32 cells per
// cycle, and busy stays high meanwhile, so no other request is taken until it ends.
// Reset is synchronous and empties the stack; cell contents are left as they are.
// The receiver cannot stall the block, so a result is never held back.
`include "assert_macros.svh"

module point_stack_with_search #(
   parameter int STACK_DEPTH = pss_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_opcode,
   input  logic [pss_pkg::POINT_W-1:0]     req_point_x,
   input  logic [pss_pkg::POINT_W-1:0]     req_point_y,
   output logic                            rsp_valid,
   output logic [pss_pkg::POINT_W-1:0]     rsp_top_x,
   output logic [pss_pkg::POINT_W-1:0]     rsp_top_y,
   output logic                            rsp_found,
   output logic                            rsp_is_empty_now,
   output logic [pss_pkg::COUNT_OUT_W-1:0] rsp_entry_count,
   output logic [1:0]                      rsp_status
);

   localparam int CountW = $clog2(STACK_DEPTH + 1);

   // Cell 0 holds the top of the stack; deeper entries sit at higher indices.
   logic [pss_pkg::ENTRY_W-1:0] entry [STACK_DEPTH];
   logic [STACK_DEPTH-1:0]      hit_vec;
   logic [STACK_DEPTH-1:0]      held;
   logic [pss_pkg::ENTRY_W-1:0] key;
   logic [CountW-1:0]           count;
   pss_pkg::cell_ctl_type       cell_ctl;

   assign key = {req_point_x, req_point_y};

   // Each cell is told whether it currently holds a live entry, so that stale data
   // below the fill level never produces a search hit.
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [pss_pkg::ENTRY_W-1:0] upper;
      logic [pss_pkg::ENTRY_W-1:0] lower;

      if (i == 0) begin : g_top
         assign upper = key;
      end else begin : g_mid
         assign upper = entry[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign lower = '0;
      end else begin : g_rest
         assign lower = entry[i+1];
      end

      assign held[i] = (count > CountW'(i));

      pss_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .key         (key),
         .upper_entry (upper),
         .lower_entry (lower),
         .held        (held[i]),
         .entry       (entry[i]),
         .hit         (hit_vec[i])
      );
   end

   pss_ctrl #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .opcode           (req_opcode),
      .top_entry        (entry[0]),
      .hit_vec          (hit_vec),
      .cell_ctl         (cell_ctl),
      .count            (count),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_top_x        (rsp_top_x),
      .rsp_top_y        (rsp_top_y),
      .rsp_found        (rsp_found),
      .rsp_is_empty_now (rsp_is_empty_now),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_status       (rsp_status)
   );

   // The fill count can never pass the depth of the chain.
   `ASSERT_NEVER(a_count_bound, clock, reset, count > CountW'(STACK_DEPTH))
   // An overflow is only reported while the stack is full.
   `ASSERT_IMPLIES(a_overflow_full, clock, reset, rsp_valid && (rsp_status == pss_pkg::STATUS_OVERFLOW), count == CountW'(STACK_DEPTH))
   // An underflow is only reported with the stack empty.
   `ASSERT_IMPLIES(a_underflow_empty, clock, reset, rsp_valid && (rsp_status == pss_pkg::STATUS_UNDERFLOW), rsp_is_empty_now && (count == '0))
   // Every request other than a search answers in the following cycle.
   `ASSERT_NEXT(a_quick_answer, clock, reset, start && !busy && (req_opcode != pss_pkg::OP_SEARCH), rsp_valid)

endmodule

FILE: bench/tb_point_stack_with_search.sv
`timescale 1ns / 1ps
// Self-checking testbench of the searchable point stack: directed table, then random runs.
module tb_point_stack_with_search;

   localparam int DEPTH = pss_pkg::STACK_DEPTH_DEFAULT;
   // Random requests issued after the directed table.
   localparam int RANDOM_REQUESTS = 1800;
   // Cycles with neither a request nor a response taken before the run is abandoned.
   // The slowest legitimate quiet stretch is a long sender gap plus a search, so
   // this leaves a wide margin.
   localparam int IDLE_LIMIT = 2000;
   // Cycles allowed after the last response for anything stray to show up.
   localparam int TAIL_CYCLES = 12;

   // One response, laid out field by field as the block presents it.
   typedef struct packed {
      logic [pss_pkg::POINT_W-1:0]     top_x;
      logic [pss_pkg::POINT_W-1:0]     top_y;
      logic                            found;
      logic                            empty;
      logic [pss_pkg::COUNT_OUT_W-1:0] count;
      logic [1:0]                      status;
   } stack_reply_type;

   // A row of the directed table; typed rows carry their response written out by hand.
   typedef struct packed {
      logic [1:0]                  opcode;
      logic [pss_pkg::POINT_W-1:0] x;
      logic [pss_pkg::POINT_W-1:0] y;
      logic                        typed;
      stack_reply_type             reply;
   } directed_row_type;

   typedef enum int {
      RUN_FILL,
      RUN_DRAIN,
      RUN_MIXED,
      RUN_CLEAR
   } run_kind_type;

   localparam int DIRECTED_ROWS = 22;

   // Covers an empty stack, both coordinate extremes, every operation, a hit on the
   // oldest entry, a near miss, clearing and underflow. Overflow needs a full stack and
   // is reached by the fill runs of the random part.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{pss_pkg::OP_POP,    8'h00, 8'h00, 1'b1,
        '{8'h00, 8'h00, 1'b0, 1'b1, 8'd0, pss_pkg::STATUS_UNDERFLOW}},
      '{pss_pkg::OP_SEARCH, 8'h00, 8'h00, 1'b1,
        '{8'h00, 8'h00, 1'b0, 1'b1, 8'd0, pss_pkg::STATUS_OK}},
      '{pss_pkg::OP_CLEAR,  8'hAA, 8'h55, 1'b1,
        '{8'h00, 8'h00, 1'b0, 1'b1, 8'd0, pss_pkg::STATUS_OK}},
      '{pss_pkg::OP_PUSH,   8'h00, 8'h00, 1'b1,
        '{8'h00, 8'h00, 1'b0, 1'b0, 8'd1, pss_pkg::STATUS_OK}},
      '{pss_pkg::OP_PUSH,   8'hFF, 8'hFF, 1'b1,
        '{8'h00, 8'h00, 1'b0, 1'b0, 8'd2, pss_pkg::STATUS_OK}},
      '{pss_pkg::OP_PUSH,   8'hFF, 8'h00, 1'b1,
        '{8'h00, 8'h00, 1'b0, 1'b0, 8'd3, pss_pkg::STATUS_OK}},
      '{pss_pkg::OP_PUSH,   8'h00, 8'hFF, 1'b1,
        '{8'h00, 8'h00, 1'b0, 1'b0, 8'd4, pss_pkg::STATUS_OK}},
      '{pss_pkg::OP_SEARCH, 8'hFF, 8'hFF, 1'b1,
        '{8'h00, 8'h00, 1'b1, 1'b0, 8'd4, pss_pkg::STATUS_OK}},
      '{pss_pkg::OP_SEARCH, 8'h00, 8'h00, 1'b1,
        '{8'h00, 8'h00, 1'b1, 1'b0, 8'd4, pss_pkg::STATUS_OK}},
      '{pss_pkg::OP_SEARCH, 8'h80, 8'h01, 1'b1,
        '{8'h00, 8'h00, 1'b0, 1'b0, 8'd4, pss_pkg::STATUS_OK}},
      '{pss_pkg::OP_SEARCH, 8'hFF, 8'hFE, 1'b1,
        '{8'h00, 8'h00, 1'b0, 1'b0, 8'd4, pss_pkg::STATUS_OK}},
      '{pss_pkg::OP_POP,    8'h00, 8'h00, 1'b1,
        '{8'h00, 8'hFF, 1'b0, 1'b0, 8'd3, pss_pkg::STATUS_OK}},
      '{pss_pkg::OP_POP,    8'h5A, 8'hA5, 1'b1,
        '{8'hFF, 8'h00, 1'b0, 1'b0, 8'd2, pss_pkg::STATUS_OK}},
      '{pss_pkg::OP_PUSH,   8'h12, 8'h34, 1'b0, '0},
      '{pss_pkg::OP_SEARCH, 8'h34, 8'h12, 1'b0, '0},
      '{pss_pkg::OP_CLEAR,  8'h00, 8'h00, 1'b1,
        '{8'h00, 8'h00, 1'b0, 1'b1, 8'd0, pss_pkg::STATUS_OK}},
      '{pss_pkg::OP_POP,    8'hFF, 8'hFF, 1'b1,
        '{8'h00, 8'h00, 1'b0, 1'b1, 8'd0, pss_pkg::STATUS_UNDERFLOW}},
      '{pss_pkg::OP_SEARCH, 8'hFF, 8'hFF, 1'b1,
        '{8'h00, 8'h00, 1'b0, 1'b1, 8'd0, pss_pkg::STATUS_OK}},
      '{pss_pkg::OP_PUSH,   8'h7F, 8'h80, 1'b0, '0},
      '{pss_pkg::OP_POP,    8'h00, 8'h00, 1'b0, '0},
      '{pss_pkg::OP_PUSH,   8'h01, 8'h02, 1'b0, '0},
      '{pss_pkg::OP_POP,    8'hC3, 8'h3C, 1'b0, '0}
   };

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic [1:0]                      req_opcode = pss_pkg::OP_PUSH;
   logic [pss_pkg::POINT_W-1:0]     req_point_x = '0;
   logic [pss_pkg::POINT_W-1:0]     req_point_y = '0;
   logic                            rsp_valid;
   logic [pss_pkg::POINT_W-1:0]     rsp_top_x;
   logic [pss_pkg::POINT_W-1:0]     rsp_top_y;
   logic                            rsp_found;
   logic                            rsp_is_empty_now;
   logic [pss_pkg::COUNT_OUT_W-1:0] rsp_entry_count;
   logic [1:0]                      rsp_status;

   // The predictor's own copy of the stack, advanced once per accepted request.
   logic [pss_pkg::ENTRY_W-1:0] held_points [DEPTH];
   int                          held_count = 0;

   // Responses still owed by the block, oldest first.
   stack_reply_type pending_replies [$];

   int mismatch_count = 0;
   int idle_cycles = 0;
   int requests_sent = 0;

   point_stack_with_search #(
      .STACK_DEPTH(DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_point_x(req_point_x),
      .req_point_y(req_point_y),
      .rsp_valid(rsp_valid),
      .rsp_top_x(rsp_top_x),
      .rsp_top_y(rsp_top_y),
      .rsp_found(rsp_found),
      .rsp_is_empty_now(rsp_is_empty_now),
      .rsp_entry_count(rsp_entry_count),
      .rsp_status(rsp_status)
   );

   always #1 clock = ~clock;

   // Applies one operation to the predictor's stack and returns the response it owes.
   function automatic stack_reply_type predict_stack_op(
         input logic [1:0] op,
         input logic [pss_pkg::POINT_W-1:0] x,
         input logic [pss_pkg::POINT_W-1:0] y);
      stack_reply_type reply;
      logic [pss_pkg::ENTRY_W-1:0] key;
      reply = '0;
      key = {x, y};
      reply.status = pss_pkg::STATUS_OK;
      case (op)
         pss_pkg::OP_PUSH: begin
            if (held_count >= DEPTH) begin
               reply.status = pss_pkg::STATUS_OVERFLOW;
            end else begin
               held_points[held_count] = key;
               held_count++;
            end
         end
         pss_pkg::OP_POP: begin
            if (held_count == 0) begin
               reply.status = pss_pkg::STATUS_UNDERFLOW;
            end else begin
               held_count--;
               {reply.top_x, reply.top_y} = held_points[held_count];
            end
         end
         pss_pkg::OP_SEARCH: begin
            for (int i = 0; i < held_count; i++) begin
               if (held_points[i] == key) reply.found = 1'b1;
            end
         end
         default: begin
            held_count = 0;
         end
      endcase
      reply.empty = (held_count == 0);
      reply.count = held_count[pss_pkg::COUNT_OUT_W-1:0];
      return reply;
   endfunction

   // Mostly back-to-back requests, some short gaps and the odd long one.
   function automatic int pick_gap(input bit quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Biased towards the extremes and towards a narrow range, so that repeats occur.
   function automatic logic [pss_pkg::POINT_W-1:0] random_coord();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      if (roll < 4) return pss_pkg::POINT_W'($urandom_range(0, 3));
      return pss_pkg::POINT_W'($urandom_range(0, 255));
   endfunction

   // Presents one request after an optional gap and holds it until the block takes it.
   // Start is only lowered when a gap follows, so it is never dropped and raised in the
   // same step.
   task automatic issue_request(input logic [1:0] op,
                                input logic [pss_pkg::POINT_W-1:0] x,
                                input logic [pss_pkg::POINT_W-1:0] y, input int gap,
                                input bit typed, input stack_reply_type typed_reply);
      stack_reply_type reply;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_point_x <= x;
      req_point_y <= y;
      do @(posedge clock); while (busy);
      reply = predict_stack_op(op, x, y);
      pending_replies.push_back(typed ? typed_reply : reply);
      requests_sent++;
   endtask

   task automatic issue_random(input logic [1:0] op, input bit quiet);
      logic [pss_pkg::POINT_W-1:0] x;
      logic [pss_pkg::POINT_W-1:0] y;
      int slot;
      x = random_coord();
      y = random_coord();
      // Half of the searches on a non-empty stack look for a point that is known to be held.
      if (op == pss_pkg::OP_SEARCH && held_count > 0 && $urandom_range(0, 1) == 1) begin
         slot = $urandom_range(0, held_count - 1);
         {x, y} = held_points[slot];
      end
      issue_request(op, x, y, pick_gap(quiet), 1'b0, '0);
   endtask

   // Stops sending until every outstanding response has been seen.
   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Response checker: the receiver cannot stall, so every strobe is a taken response.
   always @(posedge clock) begin
      stack_reply_type want;
      if (!reset && rsp_valid) begin
         if (pending_replies.size() == 0) begin
            $error("response seen with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_replies.pop_front();
            compare_field("top_x", want.top_x, rsp_top_x);
            compare_field("top_y", want.top_y, rsp_top_y);
            compare_field("found", want.found, rsp_found);
            compare_field("is_empty_now", want.empty, rsp_is_empty_now);
            compare_field("entry_count", want.count, rsp_entry_count);
            compare_field("status", want.status, rsp_status);
         end
      end
   end

   // Counts cycles in which neither a request nor a response is taken.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("point_stack_with_search verification failed");
      $finish;
   end

   initial begin
      run_kind_type kind;
      int roll;
      int run_len;
      bit quiet;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         issue_request(directed_rows[i].opcode, directed_rows[i].x, directed_rows[i].y,
                       pick_gap(1'b0), directed_rows[i].typed, directed_rows[i].reply);
      end
      // Let the block run dry once before the random part begins.
      wait_for_drain();

      // The random part is built from runs: filling to the brim and beyond, draining
      // past empty, mixed traffic, and lone clears. Some runs go without any gaps.
      while (requests_sent < DIRECTED_ROWS + RANDOM_REQUESTS) begin
         quiet = ($urandom_range(0, 4) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 20) kind = RUN_FILL;
         else if (roll < 38) kind = RUN_DRAIN;
         else if (roll < 95) kind = RUN_MIXED;
         else kind = RUN_CLEAR;
         case (kind)
            RUN_FILL: begin
               while (held_count < DEPTH) issue_random(pss_pkg::OP_PUSH, quiet);
               // Pushes against a full stack must be refused.
               repeat ($urandom_range(1, 4)) issue_random(pss_pkg::OP_PUSH, quiet);
            end
            RUN_DRAIN: begin
               while (held_count > 0) issue_random(pss_pkg::OP_POP, quiet);
               // Pops from an empty stack must report underflow.
               repeat ($urandom_range(1, 3)) issue_random(pss_pkg::OP_POP, quiet);
            end
            RUN_MIXED: begin
               run_len = $urandom_range(40, 120);
               repeat (run_len) begin
                  roll = $urandom_range(0, 99);
                  if (roll < 40) issue_random(pss_pkg::OP_PUSH, quiet);
                  else if (roll < 68) issue_random(pss_pkg::OP_POP, quiet);
                  else if (roll < 98) issue_random(pss_pkg::OP_SEARCH, quiet);
                  else issue_random(pss_pkg::OP_CLEAR, quiet);
               end
            end
            default: begin
               issue_random(pss_pkg::OP_CLEAR, quiet);
            end
         endcase
         if ($urandom_range(0, 5) == 0) wait_for_drain();
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("point_stack_with_search verification clean");
      end else begin
         $display("point_stack_with_search verification failed");
      end
      $finish;
   end

endmodule
